// ===== hw/rtl/mwps_pkg.sv =====
`default_nettype none

package mwps_pkg;

    localparam int WORD_COUNT  = 2048;
    localparam int MAX_LETTERS = 8;
    localparam int ADDR_W      = $clog2(WORD_COUNT);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int WORD_W      = 64;
    localparam int BKT_W       = 13;

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_Z = 8'h7A;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Exclusive end of each letter's bucket; an empty bucket repeats the previous end.
    localparam logic [11:0] BUCKET_END [26] = '{
        12'd136,  12'd253,  12'd439,  12'd551,  12'd651,  12'd757,  12'd833,
        12'd897,  12'd952,  12'd972,  12'd992,  12'd1068, 12'd1173, 12'd1214,
        12'd1269, 12'd1401, 12'd1409, 12'd1517, 12'd1767, 12'd1888, 12'd1923,
        12'd1969, 12'd2038, 12'd2038, 12'd2044, 12'd2048
    };

    typedef struct packed {
        logic        kind;
        logic [10:0] word_slot;
        logic [63:0] letters;
        logic [3:0]  letter_count;
    } t_in_item;

    typedef struct packed {
        logic [10:0] first_match_res;
        logic [10:0] last_match;
        logic [11:0] match_count;
        logic        exact_word;
    } t_out_item;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] prefix;
        logic [WORD_W-1:0] tail_mask;
        logic [CNT_W-1:0]  lo;
        logic [CNT_W-1:0]  hi;
    } t_query;

    function automatic t_query decode_query(input logic [63:0] letters,
                                            input logic [3:0]  cnt);
        t_query           q;
        logic [3:0]       len;
        logic             stop;
        logic [7:0]       c0;
        logic [4:0]       li;
        logic [BKT_W-1:0] lo_full;
        logic [BKT_W-1:0] hi_full;
        len  = 4'd0;
        stop = 1'b0;
        q    = '0;
        for (int k = 0; k < 8; k++) begin
            if (!stop && k < MAX_LETTERS && 4'(k) < cnt && letters[8*k +: 8] != 8'd0) begin
                len = 4'(k + 1);
            end else begin
                stop = 1'b1;
            end
        end
        for (int k = 0; k < 8; k++) begin
            if (4'(k) < len) begin
                q.prefix[8*k +: 8] = letters[8*k +: 8];
                if (k >= 1) begin
                    q.tail_mask[8*k +: 8] = 8'hFF;
                end
            end
        end
        c0      = letters[7:0];
        li      = 5'(c0 - CHAR_A);
        lo_full = '0;
        hi_full = '0;
        if (len != 4'd0 && c0 >= CHAR_A && c0 <= CHAR_Z) begin
            lo_full = (li == 5'd0) ? '0 : BKT_W'(BUCKET_END[5'(li - 5'd1)]);
            hi_full = BKT_W'(BUCKET_END[li]);
            if (hi_full > BKT_W'(WORD_COUNT)) begin
                hi_full = BKT_W'(WORD_COUNT);
            end
            q.hit = (lo_full < hi_full);
        end
        q.lo = CNT_W'(lo_full);
        q.hi = CNT_W'(hi_full);
        return q;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mwps_ram.sv =====
`default_nettype none

module mwps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mnemonic_word_prefix_search_top.sv =====
`default_nettype none

// Prefix search over a sorted word store. A load transaction (kind 0) writes one word.
// A query transaction (kind 1) is decoded in its accept cycle; an empty prefix, or a prefix
// whose first letter is outside a..z, or whose bucket is empty, goes straight to the done
// state and returns a zero result. Otherwise the block walks the letter's bucket through
// the single store read port, one word per cycle, compares the last word read in a drain
// state, and then loads the result into the output register once that register is free.
// The input is stalled for the whole query. A finished result sits in an output register,
// so the next transaction may be accepted while the result still waits to be taken. The
// store is not cleared at reset: every entry a query reaches must have been loaded first.

module mnemonic_word_prefix_search_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire mwps_pkg::t_in_item i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output mwps_pkg::t_out_item     o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                           r_state;
    logic                             r_pend;
    logic [mwps_pkg::CNT_W-1:0]       r_ptr;
    logic [mwps_pkg::CNT_W-1:0]       r_hi;
    logic [mwps_pkg::CNT_W-1:0]       r_pend_idx;
    logic [mwps_pkg::CNT_W-1:0]       r_first;
    logic [mwps_pkg::CNT_W-1:0]       r_last;
    logic                             r_found;
    logic                             r_exact;
    logic [mwps_pkg::WORD_W-1:0]      r_prefix;
    logic [mwps_pkg::WORD_W-1:0]      r_tail_mask;

    logic                             in_accept;
    logic                             out_free;
    logic                             wr_en;
    logic [mwps_pkg::WORD_W-1:0]      rd_data;
    logic                             word_match;
    logic                             word_exact;
    logic [mwps_pkg::CNT_W-1:0]       n_ptr;
    logic [mwps_pkg::CNT_W-1:0]       span;
    mwps_pkg::t_query                 qry;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !o_out_valid || !i_out_stall;
    assign qry        = mwps_pkg::decode_query(i_in_item.letters, i_in_item.letter_count);
    assign wr_en      = in_accept && (i_in_item.kind == mwps_pkg::KIND_LOAD)
                        && (13'(i_in_item.word_slot) < 13'(mwps_pkg::WORD_COUNT));
    assign word_match = ((rd_data ^ r_prefix) & r_tail_mask) == '0;
    assign word_exact = (rd_data == r_prefix);
    assign n_ptr      = r_ptr + 1'b1;
    assign span       = r_last - r_first + 1'b1;

    mwps_ram #(
        .WIDTH (mwps_pkg::WORD_W),
        .DEPTH (mwps_pkg::WORD_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (mwps_pkg::ADDR_W'(i_in_item.word_slot)),
        .i_wr_data (i_in_item.letters),
        .i_rd_addr (r_ptr[mwps_pkg::ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_ptr       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_pend <= (r_state == S_SCAN);

            // Compare the word read in the previous cycle.
            if (r_pend && word_match) begin
                if (!r_found) begin
                    r_first <= r_pend_idx;
                end
                r_last  <= r_pend_idx;
                r_found <= 1'b1;
                r_exact <= r_exact || word_exact;
            end

            // In S_DONE the result register is loaded below instead.
            if (o_out_valid && !i_out_stall && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept && i_in_item.kind == mwps_pkg::KIND_QUERY) begin
                        r_found     <= 1'b0;
                        r_exact     <= 1'b0;
                        r_prefix    <= qry.prefix;
                        r_tail_mask <= qry.tail_mask;
                        r_hi        <= qry.hi;
                        if (qry.hit) begin
                            r_ptr   <= qry.lo;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    r_pend_idx <= r_ptr;
                    if (n_ptr == r_hi) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_ptr <= n_ptr;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        if (r_found) begin
                            o_out_item.first_match_res <= 11'(r_first);
                            o_out_item.last_match      <= 11'(r_last);
                            o_out_item.match_count     <= 12'(span);
                            o_out_item.exact_word      <= r_exact;
                        end else begin
                            o_out_item <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
